[hw/rtl/asn1_hdr_pkg.sv]
// Shared constants, widths and result codes for the BER header decoder.
package asn1_hdr_pkg;

  // Limits on the number of tag groups and long-form length bytes.
  localparam int unsigned MAX_TAG_GROUPS   = 4;
  localparam int unsigned MAX_LENGTH_BYTES = 4;

  // Field widths of the input and result transactions.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TagW     = 28;
  localparam int unsigned ClassW   = 2;
  localparam int unsigned LenW     = 32;
  localparam int unsigned HdrCntW  = 4;
  localparam int unsigned ErrW     = 3;

  // Counter widths that follow from the limits.
  localparam int unsigned TagCntW  = $clog2(MAX_TAG_GROUPS + 1);
  localparam int unsigned LenLeftW = $clog2(MAX_LENGTH_BYTES + 1);

  // Result codes.
  localparam logic [ErrW-1:0] ERR_NONE       = 3'd0;
  localparam logic [ErrW-1:0] ERR_INDEF_PRIM = 3'd1;
  localparam logic [ErrW-1:0] ERR_LEN_LONG   = 3'd2;
  localparam logic [ErrW-1:0] ERR_TAG_LONG   = 3'd3;
  localparam logic [ErrW-1:0] ERR_TRUNCATED  = 3'd4;

endpackage

[hw/rtl/asn1_hdr_in_if.sv]
// Input channel: one stream byte or an end-of-stream mark per transaction.
interface asn1_hdr_in_if;
  import asn1_hdr_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);

endinterface

[hw/rtl/asn1_hdr_out_if.sv]
// Result channel: one decoded header or header error per transaction.
interface asn1_hdr_out_if;
  import asn1_hdr_pkg::*;

  logic              valid;
  logic              ready;
  logic [TagW-1:0]   tag_number;
  logic [ClassW-1:0] id_class;
  logic              constructed;
  logic              is_indefinite;
  logic [LenW-1:0]   content_length;
  logic [HdrCntW-1:0] header_bytes;
  logic [ErrW-1:0]   error_code;

  modport source (
    output valid, output tag_number, output id_class, output constructed,
    output is_indefinite, output content_length, output header_bytes,
    output error_code, input ready
  );
  modport sink (
    input valid, input tag_number, input id_class, input constructed,
    input is_indefinite, input content_length, input header_bytes,
    input error_code, output ready
  );

endinterface

[hw/rtl/asn1_ber_header_parser_top.sv]
// BER tag-length header decoder: per-byte parse state and a registered result.
//
//   Channel   Direction  Transaction
//   in_i      sink       one stream byte, or an end-of-stream mark
//   out_o     source     one decoded header, or a header error
//
// Each accepted byte updates the parse state at the edge where it is taken; a
// result, if the byte completes or breaks a header, is in out_o the next cycle.
// Throughput is one byte per cycle, except while the single result register stalls.
// in_i.ready is low only while a result is held and out_o.ready is low.
// Reset returns the parser to awaiting an identifier byte and empties out_o.
module asn1_ber_header_parser_top (
  input  logic clk_i,
  input  logic rst_ni,
  asn1_hdr_in_if.sink    in_i,
  asn1_hdr_out_if.source out_o
);
  import asn1_hdr_pkg::*;

  // Parse phase codes.
  localparam logic [1:0] PH_IDENT   = 2'd0;
  localparam logic [1:0] PH_TAG     = 2'd1;
  localparam logic [1:0] PH_LEN1    = 2'd2;
  localparam logic [1:0] PH_LENLONG = 2'd3;

  localparam logic [HdrCntW-1:0] HdrCntMax = '1;

  // Parse state.
  logic [1:0]          phase_q, phase_d;
  logic [TagW-1:0]     tag_q, tag_d;
  logic [TagCntW-1:0]  tag_cnt_q, tag_cnt_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [LenLeftW-1:0] len_left_q, len_left_d;
  logic [HdrCntW-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [ClassW-1:0]   class_q, class_d;
  logic                cons_q, cons_d;

  // Result register.
  logic                out_valid_q, out_valid_d;
  logic [TagW-1:0]     res_tag_q;
  logic [ClassW-1:0]   res_class_q;
  logic                res_cons_q;
  logic                res_indef_q;
  logic [LenW-1:0]     res_len_q;
  logic [HdrCntW-1:0]  res_hdr_q;
  logic [ErrW-1:0]     res_err_q;

  // Result of the current byte.
  logic                res_valid;
  logic                res_indef;
  logic [LenW-1:0]     res_len;
  logic [HdrCntW-1:0]  res_hdr;
  logic [ErrW-1:0]     res_err;

  logic                accept;
  logic                restart;
  logic [ByteW-1:0]    b;
  logic [HdrCntW-1:0]  hdr_inc;
  logic [LenW-1:0]     len_shift;

  // A new byte is taken whenever the result register is free or draining.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign hdr_inc    = (hdr_cnt_q != HdrCntMax) ? hdr_cnt_q + HdrCntW'(1) : hdr_cnt_q;
  assign len_shift  = {len_q[LenW-ByteW-1:0], b};

  // Per-byte decode of the header.
  always_comb begin
    phase_d    = phase_q;
    tag_d      = tag_q;
    tag_cnt_d  = tag_cnt_q;
    len_d      = len_q;
    len_left_d = len_left_q;
    hdr_cnt_d  = hdr_cnt_q;
    class_d    = class_q;
    cons_d     = cons_q;
    res_valid  = 1'b0;
    res_indef  = 1'b0;
    res_len    = '0;
    res_hdr    = hdr_inc;
    res_err    = ERR_NONE;
    restart    = 1'b0;

    if (accept) begin
      if (in_i.end_of_stream) begin
        // A clean end between headers gives nothing; inside a header it is an error.
        restart = 1'b1;
        res_hdr = hdr_cnt_q;
        if (phase_q != PH_IDENT) begin
          res_valid = 1'b1;
          res_err   = ERR_TRUNCATED;
        end
      end else begin
        hdr_cnt_d = hdr_inc;
        unique case (phase_q)
          PH_IDENT: begin
            class_d = b[7:6];
            cons_d  = b[5];
            if (b[4:0] == 5'h1F) begin
              tag_d     = '0;
              tag_cnt_d = '0;
              phase_d   = PH_TAG;
            end else begin
              tag_d   = TagW'(b[4:0]);
              phase_d = PH_LEN1;
            end
          end
          PH_TAG: begin
            if (tag_cnt_q >= TagCntW'(MAX_TAG_GROUPS) || tag_q[TagW-1:TagW-7] != '0) begin
              res_valid = 1'b1;
              res_err   = ERR_TAG_LONG;
            end else begin
              tag_cnt_d = tag_cnt_q + TagCntW'(1);
              tag_d     = {tag_q[TagW-8:0], b[6:0]};
              if (!b[7]) begin
                phase_d = PH_LEN1;
              end
            end
          end
          PH_LEN1: begin
            if (b == 8'h80) begin
              // Indefinite form is legal only for a constructed encoding.
              res_valid = 1'b1;
              res_indef = 1'b1;
              res_err   = cons_q ? ERR_NONE : ERR_INDEF_PRIM;
            end else if (!b[7]) begin
              res_valid = 1'b1;
              res_len   = LenW'(b[6:0]);
            end else if (b[6:0] > 7'(MAX_LENGTH_BYTES)) begin
              res_valid = 1'b1;
              res_err   = ERR_LEN_LONG;
            end else begin
              len_d      = '0;
              len_left_d = LenLeftW'(b[6:0]);
              phase_d    = PH_LENLONG;
            end
          end
          PH_LENLONG: begin
            if (len_q[LenW-1:LenW-ByteW] != '0) begin
              res_valid = 1'b1;
              res_err   = ERR_LEN_LONG;
            end else begin
              len_d = len_shift;
              if (len_left_q <= LenLeftW'(1)) begin
                res_valid = 1'b1;
                res_len   = len_shift;
              end else begin
                len_left_d = len_left_q - LenLeftW'(1);
              end
            end
          end
          default: begin
            restart = 1'b1;
          end
        endcase
      end

      // Every result, and a clean end, starts the next header from scratch.
      if (res_valid || restart) begin
        phase_d    = PH_IDENT;
        tag_d      = '0;
        tag_cnt_d  = '0;
        len_d      = '0;
        len_left_d = '0;
        hdr_cnt_d  = '0;
        class_d    = '0;
        cons_d     = 1'b0;
      end
    end
  end

  // Result register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDENT;
      tag_q       <= '0;
      tag_cnt_q   <= '0;
      len_q       <= '0;
      len_left_q  <= '0;
      hdr_cnt_q   <= '0;
      class_q     <= '0;
      cons_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      tag_q       <= tag_d;
      tag_cnt_q   <= tag_cnt_d;
      len_q       <= len_d;
      len_left_q  <= len_left_d;
      hdr_cnt_q   <= hdr_cnt_d;
      class_q     <= class_d;
      cons_q      <= cons_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded when a byte produces a result.
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      res_tag_q   <= tag_q;
      res_class_q <= class_q;
      res_cons_q  <= cons_q;
      res_indef_q <= res_indef;
      res_len_q   <= res_len;
      res_hdr_q   <= res_hdr;
      res_err_q   <= res_err;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.tag_number     = res_tag_q;
  assign out_o.id_class       = res_class_q;
  assign out_o.constructed    = res_cons_q;
  assign out_o.is_indefinite  = res_indef_q;
  assign out_o.content_length = res_len_q;
  assign out_o.header_bytes   = res_hdr_q;
  assign out_o.error_code     = res_err_q;

  // A new result only follows an accepted transaction.
  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept))
    else $error("result appeared without an accepted transaction");

  // After any result the parser waits for a fresh identifier byte.
  a_restart_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res_valid) |=> (phase_q == PH_IDENT && hdr_cnt_q == '0))
    else $error("parser did not restart after a result");

  // An indefinite header never carries a content length.
  a_indef_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_indef_q) |-> (res_len_q == '0))
    else $error("indefinite header with nonzero length");

  // Every result covers at least one header byte.
  a_result_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_hdr_q != '0))
    else $error("result with an empty header count");

  // The long-form byte counter never exceeds its limit.
  a_len_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_left_q <= LenLeftW'(MAX_LENGTH_BYTES))
    else $error("length byte counter out of range");

endmodule
